FILE: rtl/wdtce_pkg.sv
// Package for the watchdog with timed change enable.
// Holds request codes, sizes, the timeout table and the shared struct types.
// No dependencies.
package wdtce_pkg;

    localparam int COUNT_BITS           = 13;
    localparam int CHANGE_WINDOW_CYCLES = 4;
    localparam int WIN_BITS             = 3;
    localparam int REQ_BITS             = 3;
    localparam int CODE_BITS            = 4;

    localparam logic [REQ_BITS-1:0] REQ_IDLE         = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_WRITE_CTRL   = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_READ_CTRL    = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_KICK         = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_WRITE_STATUS = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_READ_STATUS  = 3'd5;

    localparam logic [WIN_BITS-1:0] WIN_LOAD = WIN_BITS'(CHANGE_WINDOW_CYCLES);

    typedef struct packed {
        logic [REQ_BITS-1:0] req_type;
        logic [7:0]          write_data;
        logic                ms_tick;
    } wdtce_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       system_reset;
        logic       irq;
        logic       running;
    } wdtce_result_t;

    typedef struct packed {
        logic                  int_flag;
        logic                  int_enable;
        logic [CODE_BITS-1:0]  prescale_code;
        logic                  reset_enable;
        logic [WIN_BITS-1:0]   change_window;
        logic                  reset_flag;
        logic [COUNT_BITS-1:0] elapsed_ms;
    } wdtce_state_t;

    function automatic logic [COUNT_BITS-1:0] timeout_ms(input logic [CODE_BITS-1:0] code);
        logic [COUNT_BITS-1:0] t;
        unique case (code)
            4'd0:    t = COUNT_BITS'(16);
            4'd1:    t = COUNT_BITS'(32);
            4'd2:    t = COUNT_BITS'(64);
            4'd3:    t = COUNT_BITS'(125);
            4'd4:    t = COUNT_BITS'(250);
            4'd5:    t = COUNT_BITS'(500);
            4'd6:    t = COUNT_BITS'(1000);
            4'd7:    t = COUNT_BITS'(2000);
            4'd8:    t = COUNT_BITS'(4000);
            default: t = COUNT_BITS'(8000);
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/wdtce_if.sv
// Handshake interfaces for the watchdog input beats and result beats.
// Depends on wdtce_pkg for field widths.
interface wdtce_in_if
    import wdtce_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [REQ_BITS-1:0] req_type;
    logic [7:0]          write_data;
    logic                ms_tick;

    modport source (output valid, output req_type, output write_data, output ms_tick,
                    input ready);
    modport sink (input valid, input req_type, input write_data, input ms_tick,
                  output ready);
endinterface

interface wdtce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       system_reset;
    logic       irq;
    logic       running;

    modport source (output valid, output read_data, output system_reset, output irq,
                    output running, input ready);
    modport sink (input valid, input read_data, input system_reset, input irq,
                  input running, output ready);
endinterface

FILE: rtl/watchdog_with_timed_change_enable_core.sv
// Top level of the watchdog with timed change enable: input register, step logic,
// watchdog state and result register. Depends on wdtce_pkg, wdtce_if, wdtce_input_stage
// and wdtce_step.
//
//   channel   direction  beat contents
//   items     in         req_type, write_data, ms_tick (one CPU bus cycle)
//   results   out        read_data, system_reset, irq, running
//
// One beat is accepted per clock while items.ready is high; each passes both registers.
// The watchdog state is updated in the same cycle that a result is loaded.
// rst_n clears the state and both stage valids asynchronously.
// A stall on results holds the result register and then the input register,
// and items.ready falls only when both are full.
module watchdog_with_timed_change_enable_core
    import wdtce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wdtce_in_if.sink      items,
    wdtce_out_if.source   results
);

    logic          s1_valid;
    wdtce_item_t   s1_item;
    wdtce_item_t   in_item;
    logic          out_free;
    logic          advance;
    logic          load;
    wdtce_state_t  state_reg;
    wdtce_state_t  state_next;
    wdtce_result_t step_res;
    logic          out_valid_reg;
    logic          out_valid_next;
    wdtce_result_t out_res_reg;

    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = s1_valid && out_free;
    assign items.ready = !s1_valid || advance;
    assign load        = items.valid && items.ready;

    assign in_item.req_type   = items.req_type;
    assign in_item.write_data = items.write_data;
    assign in_item.ms_tick    = items.ms_tick;

    wdtce_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .drain      (advance),
        .item       (in_item),
        .held_valid (s1_valid),
        .held_item  (s1_item)
    );

    wdtce_step u_step (
        .cur  (state_reg),
        .item (s1_item),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.read_data    = out_res_reg.read_data;
    assign results.system_reset = out_res_reg.system_reset;
    assign results.irq          = out_res_reg.irq;
    assign results.running      = out_res_reg.running;

    // The change window never holds more than its full length.
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.change_window <= WIN_LOAD)
        else $error("change window above its load value");

    // A watchdog reset leaves only the reset flag set in the state.
    a_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.system_reset) |=>
            (state_reg.reset_flag && !state_reg.reset_enable && !state_reg.int_enable
             && state_reg.elapsed_ms == '0 && state_reg.change_window == '0))
        else $error("state not cleared after watchdog reset");

    // A reset result always reports the watchdog as running.
    a_reset_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.system_reset) |-> out_res_reg.running)
        else $error("reset result without running");

    // The state moves only when a beat passes the step logic.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a beat");

    // Input is refused only while both stages hold beats.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> (s1_valid && out_valid_reg))
        else $error("input stalled with a free stage");

endmodule

FILE: rtl/wdtce_input_stage.sv
// Input register for the watchdog: captures one input beat per cycle while load is high.
// Depends on wdtce_pkg.
module wdtce_input_stage
    import wdtce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        drain,
    input  wdtce_item_t item,
    output logic        held_valid,
    output wdtce_item_t held_item
);

    logic        valid_reg;
    logic        valid_next;
    wdtce_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: rtl/wdtce_step.sv
// Next-state and result logic of the watchdog for one CPU bus cycle.
// Depends on wdtce_pkg.
module wdtce_step
    import wdtce_pkg::*;
(
    input  wdtce_state_t  cur,
    input  wdtce_item_t   item,
    output wdtce_state_t  nxt,
    output wdtce_result_t res
);

    logic                  window_open;
    logic                  wde_eff;
    logic                  sys_reset;
    logic [7:0]            rd;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] count_next;
    wdtce_state_t          s;

    assign window_open = (cur.change_window != '0);

    always_comb
    begin
        rd = 8'd0;
        if (item.req_type == REQ_READ_CTRL)
        begin
            rd = {cur.int_flag, cur.int_enable, cur.prescale_code[3], window_open,
                  cur.reset_enable | cur.reset_flag, cur.prescale_code[2:0]};
        end
        else if (item.req_type == REQ_READ_STATUS)
        begin
            rd = {4'd0, cur.reset_flag, 3'd0};
        end
    end

    always_comb
    begin
        s         = cur;
        sys_reset = 1'b0;
        sum        = {1'b0, cur.elapsed_ms} + {{COUNT_BITS{1'b0}}, 1'b1};
        count_next = '0;

        if (item.req_type == REQ_WRITE_CTRL)
        begin
            if (item.write_data[7])
            begin
                s.int_flag = 1'b0;
            end
            s.int_enable = item.write_data[6];
            if (window_open)
            begin
                s.reset_enable  = item.write_data[3];
                s.prescale_code = {item.write_data[5], item.write_data[2:0]};
            end
            else
            begin
                s.reset_enable = cur.reset_enable | item.write_data[3];
            end
            s.change_window = (item.write_data[4] && item.write_data[3]) ? WIN_LOAD : '0;
        end
        else
        begin
            if (window_open)
            begin
                s.change_window = cur.change_window - WIN_BITS'(1);
            end
            if (item.req_type == REQ_KICK)
            begin
                s.elapsed_ms = '0;
            end
            else if (item.req_type == REQ_WRITE_STATUS && !item.write_data[3])
            begin
                s.reset_flag = 1'b0;
            end
        end

        wde_eff = s.reset_enable | s.reset_flag;
        sum     = {1'b0, s.elapsed_ms} + {{COUNT_BITS{1'b0}}, 1'b1};
        count_next = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

        if (!wde_eff && !s.int_enable)
        begin
            s.elapsed_ms = '0;
        end
        else if (item.ms_tick)
        begin
            if (count_next >= timeout_ms(s.prescale_code))
            begin
                s.elapsed_ms = '0;
                if (!wde_eff || (s.int_enable && !s.int_flag))
                begin
                    s.int_flag = 1'b1;
                end
                else
                begin
                    sys_reset = 1'b1;
                end
            end
            else
            begin
                s.elapsed_ms = count_next;
            end
        end

        if (sys_reset)
        begin
            s            = '0;
            s.reset_flag = 1'b1;
        end
    end

    assign nxt              = s;
    assign res.read_data    = rd;
    assign res.system_reset = sys_reset;
    assign res.irq          = s.int_flag & s.int_enable;
    assign res.running      = s.reset_flag | s.reset_enable;

endmodule

FILE: sim/tb_watchdog_with_timed_change_enable_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for watchdog_with_timed_change_enable_core: bus beats in, one
// result per beat out, predicted by a cycle-level model of the watchdog state.
// Depends on wdtce_pkg, the wdtce_in_if and wdtce_out_if interfaces and the core RTL.
module tb_watchdog_with_timed_change_enable_core;
    import wdtce_pkg::*;

    localparam logic [REQ_BITS-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_BITS-1:0] REQ_SPARE_B = 3'd7;

    localparam logic [7:0] WDIF = 8'h80;
    localparam logic [7:0] WDIE = 8'h40;
    localparam logic [7:0] WDP3 = 8'h20;
    localparam logic [7:0] WDCE = 8'h10;
    localparam logic [7:0] WDE  = 8'h08;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 40;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    wdtce_in_if  items_if();
    wdtce_out_if results_if();

    watchdog_with_timed_change_enable_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    wdtce_item_t   pending_items[$];
    wdtce_result_t expected_results[$];
    wdtce_item_t   offered;
    int unsigned   beats_queued;
    int unsigned   src_idle_pct;
    int unsigned   snk_idle_pct;
    int unsigned   holds_requested;
    int unsigned   holds_done;
    int            hold_left;
    int            quiet_cycles;
    int            mismatches;

    int unsigned timeout_by_code [0:15] = '{16, 32, 64, 125, 250, 500, 1000, 2000,
                                            4000, 8000, 8000, 8000, 8000, 8000, 8000, 8000};

    logic                  wdt_int_flag     = 1'b0;
    logic                  wdt_int_enable   = 1'b0;
    logic [CODE_BITS-1:0]  wdt_code         = '0;
    logic                  wdt_reset_enable = 1'b0;
    logic [WIN_BITS-1:0]   wdt_window       = '0;
    logic                  wdt_reset_flag   = 1'b0;
    logic [COUNT_BITS-1:0] wdt_elapsed      = '0;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic wdtce_result_t step_watchdog(input wdtce_item_t beat);
        wdtce_result_t res;
        logic          win_open;
        logic          wde_eff;
        logic          fire_reset;
        int unsigned   next_count;
        win_open   = (wdt_window != '0);
        fire_reset = 1'b0;
        res        = '0;
        if (beat.req_type == REQ_READ_CTRL)
            res.read_data = {wdt_int_flag, wdt_int_enable, wdt_code[3], win_open,
                             wdt_reset_enable | wdt_reset_flag, wdt_code[2:0]};
        else if (beat.req_type == REQ_READ_STATUS)
            res.read_data = {4'b0000, wdt_reset_flag, 3'b000};

        if (beat.req_type == REQ_WRITE_CTRL)
        begin
            if (beat.write_data[7])
                wdt_int_flag = 1'b0;
            wdt_int_enable = beat.write_data[6];
            if (win_open)
            begin
                wdt_reset_enable = beat.write_data[3];
                wdt_code         = {beat.write_data[5], beat.write_data[2:0]};
            end
            else
                wdt_reset_enable = wdt_reset_enable | beat.write_data[3];
            wdt_window = (beat.write_data[4] && beat.write_data[3]) ? WIN_LOAD : '0;
        end
        else
        begin
            if (wdt_window != '0)
                wdt_window = wdt_window - WIN_BITS'(1);
            if (beat.req_type == REQ_KICK)
                wdt_elapsed = '0;
            else if (beat.req_type == REQ_WRITE_STATUS && !beat.write_data[3])
                wdt_reset_flag = 1'b0;
        end

        wde_eff = wdt_reset_enable | wdt_reset_flag;
        if (!wde_eff && !wdt_int_enable)
            wdt_elapsed = '0;
        else if (beat.ms_tick)
        begin
            next_count = 32'(wdt_elapsed) + 32'd1;
            if (next_count > (1 << COUNT_BITS) - 1)
                next_count = (1 << COUNT_BITS) - 1;
            if (next_count >= timeout_by_code[wdt_code])
            begin
                wdt_elapsed = '0;
                if (!wde_eff)
                    wdt_int_flag = 1'b1;
                else if (wdt_int_enable && !wdt_int_flag)
                    wdt_int_flag = 1'b1;
                else
                    fire_reset = 1'b1;
            end
            else
                wdt_elapsed = next_count[COUNT_BITS-1:0];
        end

        if (fire_reset)
        begin
            wdt_int_flag     = 1'b0;
            wdt_int_enable   = 1'b0;
            wdt_code         = '0;
            wdt_reset_enable = 1'b0;
            wdt_window       = '0;
            wdt_elapsed      = '0;
            wdt_reset_flag   = 1'b1;
        end

        res.system_reset = fire_reset;
        res.irq          = wdt_int_flag & wdt_int_enable;
        res.running      = wdt_reset_flag | wdt_reset_enable;
        return res;
    endfunction

    task automatic add_beat(input logic [REQ_BITS-1:0] req, input logic [7:0] data,
                            input logic tick);
        wdtce_item_t beat;
        beat.req_type   = req;
        beat.write_data = data;
        beat.ms_tick    = tick;
        pending_items.push_back(beat);
        beats_queued++;
    endtask

    task automatic add_random_sequence();
        int unsigned kind;
        int unsigned n;
        int unsigned r;
        logic [7:0]  b;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // Write a random control byte and let the timer run on ticks, with the odd kick or read.
            add_beat(REQ_WRITE_CTRL, rand_byte(), rand_bit());
            n = $urandom_range(8, 30);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    add_beat(REQ_IDLE, rand_byte(), 1'b1);
                else if (r < 85)
                    add_beat(REQ_KICK, rand_byte(), rand_bit());
                else if (r < 93)
                    add_beat(REQ_READ_CTRL, rand_byte(), rand_bit());
                else
                    add_beat(REQ_READ_STATUS, rand_byte(), rand_bit());
            end
        end
        else if (kind < 55)
        begin
            // Timed change: open the window, some other beats, then the new setting.
            b = rand_byte();
            add_beat(REQ_WRITE_CTRL, b | WDCE | WDE, rand_bit());
            n = $urandom_range(0, CHANGE_WINDOW_CYCLES);
            repeat (n)
            begin
                r = $urandom_range(0, 4);
                case (r)
                    0:       add_beat(REQ_IDLE, rand_byte(), rand_bit());
                    1:       add_beat(REQ_READ_CTRL, rand_byte(), rand_bit());
                    2:       add_beat(REQ_KICK, rand_byte(), rand_bit());
                    3:       add_beat(REQ_READ_STATUS, rand_byte(), rand_bit());
                    default: add_beat(REQ_WRITE_STATUS, rand_byte(), rand_bit());
                endcase
            end
            b = rand_byte();
            if ($urandom_range(0, 3) != 0)
            begin
                b[5]   = 1'b0;
                b[2:0] = 3'($urandom_range(0, 2));
            end
            add_beat(REQ_WRITE_CTRL, b, rand_bit());
        end
        else if (kind < 65)
        begin
            add_beat(REQ_READ_STATUS, rand_byte(), rand_bit());
            add_beat(REQ_WRITE_STATUS, rand_byte(), rand_bit());
            add_beat(REQ_READ_CTRL, rand_byte(), rand_bit());
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                add_beat(REQ_BITS'($urandom_range(0, 7)), rand_byte(), rand_bit());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (items_if.valid && items_if.ready)
                expected_results.push_back(step_watchdog(offered));
            if (!items_if.valid || items_if.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    items_if.valid      <= 1'b1;
                    items_if.req_type   <= offered.req_type;
                    items_if.write_data <= offered.write_data;
                    items_if.ms_tick    <= offered.ms_tick;
                end
                else
                    items_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                results_if.ready <= 1'b0;
            end
            else if (holds_done != holds_requested)
            begin
                holds_done <= holds_done + 1;
                hold_left  <= LONG_HOLD;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        wdtce_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (results_if.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data,
                           results_if.read_data);
                    mismatches++;
                end
                if (results_if.system_reset !== want.system_reset)
                begin
                    $error("system_reset: expected %b, got %b", want.system_reset,
                           results_if.system_reset);
                    mismatches++;
                end
                if (results_if.irq !== want.irq)
                begin
                    $error("irq: expected %b, got %b", want.irq, results_if.irq);
                    mismatches++;
                end
                if (results_if.running !== want.running)
                begin
                    $error("running: expected %b, got %b", want.running, results_if.running);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** watchdog_with_timed_change_enable_core: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        items_if.valid      = 1'b0;
        items_if.req_type   = REQ_IDLE;
        items_if.write_data = 8'h00;
        items_if.ms_tick    = 1'b0;
        results_if.ready    = 1'b0;
        beats_queued        = 0;
        holds_requested     = 0;
        holds_done          = 0;
        hold_left           = 0;
        quiet_cycles        = 0;
        mismatches          = 0;
        src_idle_pct        = 16;
        snk_idle_pct        = 55;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_beat(REQ_READ_CTRL, 8'h00, 1'b0);
        add_beat(REQ_READ_STATUS, 8'hFF, 1'b0);
        add_beat(REQ_SPARE_A, 8'hFF, 1'b1);
        add_beat(REQ_SPARE_B, 8'h00, 1'b0);
        add_beat(REQ_WRITE_CTRL, WDIE, 1'b1);
        add_beat(REQ_WRITE_CTRL, WDIE | WDCE | WDE, 1'b0);
        add_beat(REQ_READ_CTRL, 8'h00, 1'b1);
        add_beat(REQ_WRITE_CTRL, WDIE | WDP3 | 8'h07, 1'b0);
        add_beat(REQ_WRITE_CTRL, WDCE | WDE, 1'b0);
        add_beat(REQ_WRITE_CTRL, WDIF | WDCE | WDE, 1'b1);
        add_beat(REQ_KICK, 8'hFF, 1'b1);
        repeat (CHANGE_WINDOW_CYCLES) add_beat(REQ_IDLE, 8'h00, 1'b1);
        add_beat(REQ_READ_CTRL, 8'h00, 1'b0);
        add_beat(REQ_WRITE_CTRL, WDP3 | 8'h07, 1'b1);
        add_beat(REQ_WRITE_STATUS, 8'h00, 1'b0);
        add_beat(REQ_WRITE_STATUS, 8'hFF, 1'b0);
        add_beat(REQ_READ_STATUS, 8'h00, 1'b0);
        add_beat(REQ_WRITE_CTRL, 8'hFF, 1'b1);

        while (beats_queued < 170)
            add_random_sequence();
        while (pending_items.size() != 0)
            @(posedge clk);

        src_idle_pct = 55;
        snk_idle_pct = 16;
        while (beats_queued < 320)
            add_random_sequence();
        while (pending_items.size() != 0)
            @(posedge clk);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (beats_queued < 470)
            add_random_sequence();
        repeat (20) @(posedge clk);
        holds_requested = 1;
        while (pending_items.size() != 0 || items_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("** watchdog_with_timed_change_enable_core: PASSED **");
        else
            $display("** watchdog_with_timed_change_enable_core: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/wdtce_pkg.sv
rtl/wdtce_if.sv
rtl/wdtce_input_stage.sv
rtl/wdtce_step.sv
rtl/watchdog_with_timed_change_enable_core.sv
sim/tb_watchdog_with_timed_change_enable_core.sv
